### sv/plps_pkg.sv
package plps_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LIGHT_X         = 3'd0,
    CFG_LIGHT_Y         = 3'd1,
    CFG_LIGHT_Z         = 3'd2,
    CFG_PHONG_PEAK      = 3'd3,
    CFG_PHONG_SHARPNESS = 3'd4,
    CFG_AMBIENT_LEVEL   = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] LIGHT_X_RESET   = 32'hFFFE_0000;
  localparam logic [31:0] LIGHT_Y_RESET   = 32'hFFFB_0000;
  localparam logic [31:0] LIGHT_Z_RESET   = 32'hFFFB_0000;
  localparam logic [15:0] PEAK_RESET      = 16'd39322;
  localparam logic [15:0] SHARP_RESET     = 16'd7680;
  localparam logic [15:0] AMBIENT_RESET   = 16'd2621;

  // Arithmetic widths and constants.
  localparam int SQ_VW    = 64;   // squared distance sum
  localparam int SQ_RW    = 32;   // root width
  localparam int DIV_NW   = 46;   // dividend width
  localparam int DIV_QB   = 17;   // quotient bits below the saturation check
  localparam int LOG_XW   = 42;   // log2 argument width
  localparam int LOG_FB   = 16;   // log2 fraction bits
  localparam int LOG_LW   = 24;   // log2 result width

  localparam logic [DIV_NW-1:0] ATTEN_NUM = DIV_NW'(64'd20 << 31);
  localparam logic [16:0] UNIT_Q14   = 17'd16384;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [15:0] EXP_C1     = 16'd43024;
  localparam logic [15:0] EXP_C2     = 16'd22512;
  localparam logic [23:0] COIN_VALUE = 24'hFF0000;
  localparam logic [23:0] RES_MAX    = 24'hFFFFFF;

  // Sideband carried through the square root.
  typedef struct packed {
    logic             coin;
    logic [2:0]       neg;
    logic [2:0][31:0] ad;
    logic [2:0][15:0] n;
    logic [2:0][15:0] v;
  } head_t;

  // Sideband carried through the attenuation divider.
  typedef struct packed {
    logic             coin;
    logic [2:0][15:0] n;
    logic [2:0][15:0] v;
  } mid_t;

  // Sideband carried through the log2 unit.
  typedef struct packed {
    logic        coin;
    logic        a_neg;
    logic        hl_en;
    logic [20:0] ab;
  } tail_t;

endpackage

### sv/plps_isqrt.sv
module plps_isqrt #(
  parameter int VW = 64,
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_value,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  localparam int TW = VW + 2;

  logic          vld_q  [RW];
  logic [VW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int J = RW - 1 - k;
    logic          vld_i;
    logic [VW-1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] side_i;
    logic [TW-1:0] trial;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = in_value;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign side_i = side_q[k-1];
    end

    // Growth of the square when bit J is added to the partial root.
    assign trial = (TW'(root_i) << (J + 1)) + (TW'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k] <= side_i;
        if (TW'(rem_i) >= trial) begin
          rem_q[k]  <= rem_i - trial[VW-1:0];
          root_q[k] <= root_i | (RW'(1) << J);
        end else begin
          rem_q[k]  <= rem_i;
          root_q[k] <= root_i;
        end
      end
    end
  end

  assign out_valid = vld_q[RW-1];
  assign out_root  = root_q[RW-1];
  assign out_side  = side_q[RW-1];

endmodule

### sv/plps_div.sv
module plps_div #(
  parameter int NW = 46,
  parameter int DW = 32,
  parameter int QB = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_quot,
  output logic          out_sat,
  output logic [SW-1:0] out_side
);

  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic          vld_q  [QB+1];
  logic [NW-1:0] rem_q  [QB+1];
  logic [DW-1:0] den_q  [QB+1];
  logic [QB-1:0] quot_q [QB+1];
  logic          sat_q  [QB+1];
  logic [SW-1:0] side_q [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  // First stage flags a quotient too large for the kept bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= in_num;
      den_q[0]  <= in_den;
      quot_q[0] <= '0;
      sat_q[0]  <= (CW'(in_num) >= (CW'(in_den) << QB));
      side_q[0] <= in_side;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int J = QB - k;
    logic [CW-1:0] shifted;

    assign shifted = CW'(den_q[k-1]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k]  <= den_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        side_q[k] <= side_q[k-1];
        if (CW'(rem_q[k-1]) >= shifted) begin
          rem_q[k]  <= rem_q[k-1] - shifted[NW-1:0];
          quot_q[k] <= quot_q[k-1] | (QB'(1) << J);
        end else begin
          rem_q[k]  <= rem_q[k-1];
          quot_q[k] <= quot_q[k-1];
        end
      end
    end
  end

  assign out_valid = vld_q[QB];
  assign out_quot  = quot_q[QB];
  assign out_sat   = sat_q[QB];
  assign out_side  = side_q[QB];

endmodule

### sv/plps_log2.sv
module plps_log2 #(
  parameter int XW = 42,
  parameter int FB = 16,
  parameter int LW = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [XW-1:0] in_x,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [LW-1:0] out_log,
  output logic [SW-1:0] out_side
);

  localparam int KW = $clog2(XW);
  localparam int WW = XW + 31;

  // Leading one search.
  logic          enc_vld;
  logic [KW-1:0] enc_k;
  logic [XW-1:0] enc_x;
  logic [SW-1:0] enc_side;
  logic [KW-1:0] k_c;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < XW; i++) begin
      if (in_x[i]) begin
        k_c = KW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_vld <= 1'b0;
    end else if (en) begin
      enc_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enc_k    <= k_c;
      enc_x    <= in_x;
      enc_side <= in_side;
    end
  end

  // Normalize the mantissa to Q1.30.
  logic          vld_q  [FB+1];
  logic [30:0]   m_q    [FB+1];
  logic [FB-1:0] frac_q [FB+1];
  logic [KW-1:0] k_q    [FB+1];
  logic [SW-1:0] side_q [FB+1];
  logic [WW-1:0] norm_c;

  always_comb begin
    if (enc_k >= KW'(30)) begin
      norm_c = WW'(enc_x) >> (enc_k - KW'(30));
    end else begin
      norm_c = WW'(enc_x) << (KW'(30) - enc_k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= enc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0]    <= norm_c[30:0];
      frac_q[0] <= '0;
      k_q[0]    <= enc_k;
      side_q[0] <= enc_side;
    end
  end

  // One fraction bit per stage by squaring the mantissa.
  for (genvar s = 1; s <= FB; s++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;

    assign sq = 62'(m_q[s-1]) * 62'(m_q[s-1]);
    assign sh = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        k_q[s]    <= k_q[s-1];
        side_q[s] <= side_q[s-1];
        frac_q[s] <= {frac_q[s-1][FB-2:0], sh[31]};
        m_q[s]    <= sh[31] ? sh[31:1] : sh[30:0];
      end
    end
  end

  logic [LW-FB-1:0] ipart;

  assign ipart     = (LW-FB)'(k_q[FB]) - (LW-FB)'(28);
  assign out_valid = vld_q[FB];
  assign out_log   = {ipart, frac_q[FB]};
  assign out_side  = side_q[FB];

endmodule

### sv/phong_point_light_shader_unit.sv
// Phong point-light shader. Each input beat carries a surface point, its unit
// normal and the unit view direction; each output beat carries the brightness
// in unsigned Q8.16 and a flag that is set when the point sits exactly on the
// light (brightness is then 255.0). The light position, highlight peak,
// highlight sharpness and ambient level are to be written by the user through
// the register port only while the pipeline is empty; the block itself does
// not enforce this. The block takes one beat per clock. Three stages form a
// quarter of the squared distance, 32 stages take the square root one bit at
// a time, 18 stages normalize the light vector and the distance term by
// restoring division, 18 stages form log2 of the highlight base by repeated
// squaring, and the rest are dot products, the power and the final sum. The
// whole pipeline holds while the output beat is not taken.
module phong_point_light_shader_unit (
  input  logic         clk,
  input  logic         rst,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z,
  // view_x, view_y, view_z
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  // brightness
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,
  // light_coincident
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  import plps_pkg::*;

  // Configuration registers.
  logic [31:0] light_x, light_y, light_z;
  logic [15:0] phong_peak, phong_sharpness, ambient_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x         <= LIGHT_X_RESET;
      light_y         <= LIGHT_Y_RESET;
      light_z         <= LIGHT_Z_RESET;
      phong_peak      <= PEAK_RESET;
      phong_sharpness <= SHARP_RESET;
      ambient_level   <= AMBIENT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIGHT_X:         light_x         <= cfg_data;
        CFG_LIGHT_Y:         light_y         <= cfg_data;
        CFG_LIGHT_Z:         light_z         <= cfg_data;
        CFG_PHONG_PEAK:      phong_peak      <= cfg_data[15:0];
        CFG_PHONG_SHARPNESS: phong_sharpness <= cfg_data[15:0];
        CFG_AMBIENT_LEVEL:   ambient_level   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output beat is held.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: light vector, magnitudes and the coincidence test.
  logic [2:0][31:0] lpos, ppos;
  logic [2:0][32:0] dvec, dabs;
  assign lpos = {light_z, light_y, light_x};
  assign ppos = s_axis_tdata[95:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvec[i] = {lpos[i][31], lpos[i]} - {ppos[i][31], ppos[i]};
      dabs[i] = dvec[i][32] ? (33'd0 - dvec[i]) : dvec[i];
    end
  end

  logic  s1_vld;
  head_t s1_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_h.coin <= (dvec == '0);
      for (int i = 0; i < 3; i++) begin
        s1_h.neg[i] <= dvec[i][32];
        s1_h.ad[i]  <= dabs[i][31:0];
      end
      s1_h.n <= s_axis_tdata[143:96];
      s1_h.v <= s_axis_tdata[191:144];
    end
  end

  // Stage 2: squares of the components.
  logic             s2_vld;
  head_t            s2_h;
  logic [2:0][63:0] s2_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_h <= s1_h;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= 64'(s1_h.ad[i]) * 64'(s1_h.ad[i]);
      end
    end
  end

  // Stage 3: sum of quarter squares.
  logic        s3_vld;
  head_t       s3_h;
  logic [63:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_h   <= s2_h;
      s3_sum <= (s2_sq[0] >> 2) + (s2_sq[1] >> 2) + (s2_sq[2] >> 2);
    end
  end

  // Half the distance by square root.
  logic        sq_vld;
  logic [31:0] sq_root;
  head_t       sq_h;

  plps_isqrt #(
    .VW (SQ_VW),
    .RW (SQ_RW),
    .SW ($bits(head_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_vld),
    .in_value  (s3_sum),
    .in_side   (s3_h),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_h)
  );

  // Stage 4: dividends with rounding term.
  logic                   s4_vld;
  logic [31:0]            s4_mag;
  logic [2:0][DIV_NW-1:0] s4_num;
  logic [2:0]             s4_neg;
  mid_t                   s4_m;
  logic [31:0]            mag_c;

  assign mag_c = (sq_root == '0) ? 32'd1 : sq_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mag    <= mag_c;
      s4_neg    <= sq_h.neg;
      s4_m.coin <= sq_h.coin;
      s4_m.n    <= sq_h.n;
      s4_m.v    <= sq_h.v;
      for (int i = 0; i < 3; i++) begin
        s4_num[i] <= (DIV_NW'(sq_h.ad[i]) << 13) + DIV_NW'(mag_c >> 1);
      end
    end
  end

  // Unit light vector lanes and the attenuation lane.
  logic [2:0]             dv_vld;
  logic [2:0][DIV_QB-1:0] dv_q;
  logic [2:0]             dv_sat;
  logic [2:0]             dv_neg;
  logic                   at_vld;
  logic [DIV_QB-1:0]      at_q;
  logic                   at_sat;
  mid_t                   at_m;

  for (genvar i = 0; i < 3; i++) begin : g_unit
    plps_div #(
      .NW (DIV_NW),
      .DW (32),
      .QB (DIV_QB),
      .SW (1)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (s4_vld),
      .in_num    (s4_num[i]),
      .in_den    (s4_mag),
      .in_side   (s4_neg[i]),
      .out_valid (dv_vld[i]),
      .out_quot  (dv_q[i]),
      .out_sat   (dv_sat[i]),
      .out_side  (dv_neg[i])
    );
  end

  plps_div #(
    .NW (DIV_NW),
    .DW (32),
    .QB (DIV_QB),
    .SW ($bits(mid_t))
  ) u_atten (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s4_vld),
    .in_num    (ATTEN_NUM),
    .in_den    (s4_mag),
    .in_side   (s4_m),
    .out_valid (at_vld),
    .out_quot  (at_q),
    .out_sat   (at_sat),
    .out_side  (at_m)
  );

  // Stage 5: clamp and sign the unit vector, clamp attenuation.
  logic             s5_vld;
  logic [2:0][15:0] s5_u;
  logic [16:0]      s5_b;
  mid_t             s5_m;
  logic [2:0][14:0] uq_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uq_c[i] = (dv_sat[i] || (dv_q[i] > UNIT_Q14)) ? UNIT_Q14[14:0] : dv_q[i][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= at_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_m <= at_m;
      s5_b <= (at_sat || (at_q > ONE_Q16)) ? ONE_Q16 : at_q;
      for (int i = 0; i < 3; i++) begin
        s5_u[i] <= dv_neg[i] ? (16'd0 - {1'b0, uq_c[i]}) : {1'b0, uq_c[i]};
      end
    end
  end

  // Stage 6: Lambert products.
  logic             s6_vld;
  logic [2:0][15:0] s6_u;
  logic [16:0]      s6_b;
  mid_t             s6_m;
  logic [2:0][31:0] s6_pn;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_u <= s5_u;
      s6_b <= s5_b;
      s6_m <= s5_m;
      for (int i = 0; i < 3; i++) begin
        s6_pn[i] <= 32'($signed(s5_m.n[i]) * $signed(s5_u[i]));
      end
    end
  end

  // Stage 7: Lambert sum.
  logic             s7_vld;
  logic [2:0][15:0] s7_u;
  logic [16:0]      s7_b;
  mid_t             s7_m;
  logic [33:0]      s7_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (adv) begin
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_u <= s6_u;
      s7_b <= s6_b;
      s7_m <= s6_m;
      s7_a <= 34'($signed(s6_pn[0])) + 34'($signed(s6_pn[1])) + 34'($signed(s6_pn[2]));
    end
  end

  // Stage 8: reflection products and the attenuated Lambert term.
  logic             s8_vld;
  logic [2:0][15:0] s8_u;
  logic [2:0][15:0] s8_v;
  logic             s8_coin, s8_apos, s8_aneg;
  logic [20:0]      s8_ab;
  logic [2:0][49:0] s8_p;
  logic [48:0]      ab_c;

  assign ab_c = 49'(s7_a[31:0]) * 49'(s7_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (adv) begin
      s8_vld <= s7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_u    <= s7_u;
      s8_v    <= s7_m.v;
      s8_coin <= s7_m.coin;
      s8_aneg <= s7_a[33];
      s8_apos <= !s7_a[33] && (s7_a != '0);
      s8_ab   <= ab_c[48:28];
      for (int i = 0; i < 3; i++) begin
        s8_p[i] <= 50'($signed(s7_a) * $signed(s7_m.n[i]));
      end
    end
  end

  // Stage 9: reflected ray.
  logic             s9_vld;
  logic [2:0][15:0] s9_v;
  logic             s9_coin, s9_apos, s9_aneg;
  logic [20:0]      s9_ab;
  logic [2:0][23:0] s9_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (adv) begin
      s9_vld <= s8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_v    <= s8_v;
      s9_coin <= s8_coin;
      s9_apos <= s8_apos;
      s9_aneg <= s8_aneg;
      s9_ab   <= s8_ab;
      for (int i = 0; i < 3; i++) begin
        s9_r[i] <= 24'($signed(s8_p[i][49:27])) - 24'($signed(s8_u[i]));
      end
    end
  end

  // Stage 10: reflected ray against the view direction.
  logic             s10_vld;
  logic             s10_coin, s10_apos, s10_aneg;
  logic [20:0]      s10_ab;
  logic [2:0][39:0] s10_rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else if (adv) begin
      s10_vld <= s9_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_coin <= s9_coin;
      s10_apos <= s9_apos;
      s10_aneg <= s9_aneg;
      s10_ab   <= s9_ab;
      for (int i = 0; i < 3; i++) begin
        s10_rv[i] <= 40'($signed(s9_r[i]) * $signed(s9_v[i]));
      end
    end
  end

  // Stage 11: highlight base, negated.
  logic              s11_vld;
  tail_t             s11_t;
  logic [LOG_XW-1:0] s11_x;
  logic [41:0]       c_c;

  assign c_c = 42'($signed(s10_rv[0])) + 42'($signed(s10_rv[1]))
             + 42'($signed(s10_rv[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_vld <= 1'b0;
    end else if (adv) begin
      s11_vld <= s10_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_t.coin  <= s10_coin;
      s11_t.a_neg <= s10_aneg;
      s11_t.hl_en <= s10_apos && c_c[41];
      s11_t.ab    <= s10_ab;
      s11_x       <= LOG_XW'(42'd0 - c_c);
    end
  end

  // Logarithm of the highlight base.
  logic              lg_vld;
  logic [LOG_LW-1:0] lg_log;
  tail_t             lg_t;

  plps_log2 #(
    .XW (LOG_XW),
    .FB (LOG_FB),
    .LW (LOG_LW),
    .SW ($bits(tail_t))
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s11_vld),
    .in_x      (s11_x),
    .in_side   (s11_t),
    .out_valid (lg_vld),
    .out_log   (lg_log),
    .out_side  (lg_t)
  );

  // Stage 12: scale by the sharpness.
  logic        s12_vld;
  tail_t       s12_t;
  logic [32:0] s12_y;
  logic [40:0] ylong_c;

  assign ylong_c = 41'($signed({1'b0, phong_sharpness}) * $signed(lg_log));

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_vld <= 1'b0;
    end else if (adv) begin
      s12_vld <= lg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_t <= lg_t;
      s12_y <= ylong_c[40:8];
    end
  end

  // Stage 13: split exponent, square of the fraction.
  logic        s13_vld;
  tail_t       s13_t;
  logic [16:0] s13_ip;
  logic [15:0] s13_f;
  logic [31:0] s13_ff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_vld <= 1'b0;
    end else if (adv) begin
      s13_vld <= s12_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_t  <= s12_t;
      s13_ip <= s12_y[32:16];
      s13_f  <= s12_y[15:0];
      s13_ff <= 32'(s12_y[15:0]) * 32'(s12_y[15:0]);
    end
  end

  // Stage 14: quadratic fit of 2^f.
  logic        s14_vld;
  tail_t       s14_t;
  logic [16:0] s14_ip;
  logic [16:0] s14_mant;
  logic [32:0] poly_c;

  assign poly_c = 33'(32'(EXP_C1) * 32'(s13_f)) + 33'(32'(EXP_C2) * 32'(s13_ff[31:16]));

  always_ff @(posedge clk) begin
    if (rst) begin
      s14_vld <= 1'b0;
    end else if (adv) begin
      s14_vld <= s13_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s14_t    <= s13_t;
      s14_ip   <= s13_ip;
      s14_mant <= ONE_Q16 + poly_c[32:16];
    end
  end

  // Stage 15: apply the integer part of the exponent.
  logic        s15_vld;
  tail_t       s15_t;
  logic [25:0] s15_e;
  logic [25:0] e_c;
  logic [16:0] nip_c;

  assign nip_c = 17'd0 - s14_ip;

  always_comb begin
    if ($signed(s14_ip) > $signed(17'sd8)) begin
      e_c = 26'd1 << 25;
    end else if (!s14_ip[16]) begin
      e_c = 26'(s14_mant) << s14_ip[3:0];
    end else if ($signed(s14_ip) < -$signed(17'sd17)) begin
      e_c = '0;
    end else begin
      e_c = 26'(s14_mant >> nip_c[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s15_vld <= 1'b0;
    end else if (adv) begin
      s15_vld <= s14_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s15_t <= s14_t;
      s15_e <= e_c;
    end
  end

  // Stage 16: highlight.
  logic        s16_vld;
  tail_t       s16_t;
  logic [25:0] s16_hl;
  logic [41:0] hl_c;

  assign hl_c = 42'(phong_peak) * 42'(s15_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      s16_vld <= 1'b0;
    end else if (adv) begin
      s16_vld <= s15_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s16_t  <= s15_t;
      s16_hl <= s15_t.hl_en ? hl_c[41:16] : '0;
    end
  end

  // Stage 17: final sum into the output register.
  logic [21:0] diff_c;
  logic [16:0] lit_c;
  logic [26:0] tot_c;
  logic [23:0] res_c;

  always_comb begin
    diff_c = 22'(s16_t.ab) + 22'(ambient_level);
    lit_c  = (diff_c > 22'(ONE_Q16)) ? ONE_Q16 : diff_c[16:0];
    tot_c  = 27'(lit_c) + 27'(s16_hl);
    if (s16_t.coin) begin
      res_c = COIN_VALUE;
    end else if (s16_t.a_neg) begin
      res_c = 24'(ambient_level);
    end else if (tot_c > 27'(RES_MAX)) begin
      res_c = RES_MAX;
    end else begin
      res_c = tot_c[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s16_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= res_c;
      m_axis_tuser <= s16_t.coin;
    end
  end

endmodule
